FILE: hw/rtl/ascii_decimal_frame_builder_top_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the decimal frame builder
// Shared forms for concurrent checks, clocked on clk, quiet in reset.
// ----------------------------------------------------------------------------
`ifndef ASCII_DECIMAL_FRAME_BUILDER_TOP_DEFINES_SVH
`define ASCII_DECIMAL_FRAME_BUILDER_TOP_DEFINES_SVH

// same-cycle implication
`define ADFB_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define ADFB_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: hw/rtl/adfb_pkg.sv
// ----------------------------------------------------------------------------
// adfb_pkg
// Constants, microcode format and control program of the frame builder.
// ----------------------------------------------------------------------------
package adfb_pkg;

	localparam int FRAME_SIZE_DEF = 32;
	localparam int CNT_W          = 11;
	localparam int PC_W           = 4;
	localparam int STEPS          = 12;

	localparam logic [7:0] CH_F     = 8'h66;
	localparam logic [7:0] CH_TWO   = 8'h32;
	localparam logic [7:0] CH_SEMI  = 8'h3B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NUL   = 8'h00;

	localparam logic [PC_W-1:0] PC_HOME = 4'd0;
	localparam logic [PC_W-1:0] PC_HDR  = 4'd1;
	localparam logic [PC_W-1:0] PC_SIGN = 4'd5;

	localparam logic [2:0] PLACE_UNIT = 3'd4;

	// byte source of a step
	typedef enum logic [2:0] {
		SRC_NONE,
		SRC_F,
		SRC_TWO,
		SRC_TYPE,
		SRC_SEMI,
		SRC_SIGN,
		SRC_DIGIT,
		SRC_TAIL
	} src_t;

	// sequencing of a step
	typedef enum logic [1:0] {
		JMP_NEXT,
		JMP_DISPATCH,
		JMP_HOME,
		JMP_OVF
	} jmp_t;

	typedef struct packed {
		src_t       src;
		logic [2:0] place;
		jmp_t       jmp;
	} uop_t;

	localparam uop_t UCODE [STEPS] = '{
		'{SRC_NONE,  3'd0, JMP_DISPATCH},
		'{SRC_F,     3'd0, JMP_NEXT},
		'{SRC_TWO,   3'd0, JMP_NEXT},
		'{SRC_TYPE,  3'd0, JMP_NEXT},
		'{SRC_SEMI,  3'd0, JMP_NEXT},
		'{SRC_SIGN,  3'd0, JMP_NEXT},
		'{SRC_DIGIT, 3'd0, JMP_NEXT},
		'{SRC_DIGIT, 3'd1, JMP_NEXT},
		'{SRC_DIGIT, 3'd2, JMP_NEXT},
		'{SRC_DIGIT, 3'd3, JMP_NEXT},
		'{SRC_DIGIT, PLACE_UNIT, JMP_OVF},
		'{SRC_TAIL,  3'd0, JMP_HOME}
	};

	// weight of a decimal place, most significant first
	function automatic logic [16:0] place_weight(input logic [2:0] place);
		logic [16:0] w;
		unique case (place)
			3'd0:    w = 17'd10000;
			3'd1:    w = 17'd1000;
			3'd2:    w = 17'd100;
			3'd3:    w = 17'd10;
			default: w = 17'd1;
		endcase
		return w;
	endfunction

endpackage

FILE: hw/rtl/ascii_decimal_frame_builder_top.sv
// ----------------------------------------------------------------------------
// ascii_decimal_frame_builder_top
// Turns signed 16-bit values into an ASCII frame: "f2<type>;" header,
// decimal values separated by ';', then a NUL or the overflow flag.
// ----------------------------------------------------------------------------
// A value is taken when the sequencer is home; it then runs one step per
// cycle through a 12-word control ROM, a step waiting while the output
// register holds a byte the sink has not taken: four header steps (first
// value of a frame only), sign, five decimal places and a tail step. Each
// step emits at most one byte into the single output register; a final
// value that overflows skips the tail step. A new value is accepted while
// the last byte of the previous one still waits in the output register.

`include "ascii_decimal_frame_builder_top_defines.svh"

module ascii_decimal_frame_builder_top #(
	parameter int FRAME_SIZE = adfb_pkg::FRAME_SIZE_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // [7:0] frame_type, [23:8] data_value
	input  logic        s_tlast,   // last_value
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // [7:0] out_byte
	output logic        m_tlast,   // frame_end
	output logic        m_tuser    // overflow
);
	import adfb_pkg::*;

	logic [PC_W-1:0]  pc_q, pc_nxt;
	logic             open_q;
	logic [CNT_W-1:0] count_q;
	logic [7:0]       type_q;
	logic             neg_q;
	logic             last_q;
	logic [15:0]      mag_q;
	logic             started_q;

	uop_t        uop;
	logic        slot_free, step_go, emit, bump, close, s_req;
	logic [7:0]  obyte;
	logic        olast, ouser, ovf_hit;
	logic [3:0]  digit;
	logic [16:0] weight, sub, mult;
	logic [15:0] raw_val;

	assign uop       = UCODE[pc_q];
	assign slot_free = !m_tvalid || m_tready;
	assign s_tready  = (pc_q == PC_HOME);
	assign s_req     = s_tvalid && s_tready;
	assign step_go   = (pc_q != PC_HOME) && slot_free;
	assign raw_val   = s_tdata[23:8];
	assign ovf_hit   = (12'(count_q) + 12'd1) >= 12'(FRAME_SIZE);

	// digit of the current place: largest multiple of the weight not above mag
	always_comb begin
		weight = place_weight(uop.place);
		digit  = 4'd0;
		sub    = 17'd0;
		for (int k = 1; k <= 9; k++) begin
			mult = 17'(k) * weight;
			if ({1'b0, mag_q} >= mult) begin
				digit = 4'(k);
				sub   = mult;
			end
		end
	end

	always_comb begin
		emit   = 1'b0;
		obyte  = CH_NUL;
		olast  = 1'b0;
		ouser  = 1'b0;
		close  = 1'b0;
		pc_nxt = pc_q + 4'd1;
		unique case (uop.src)
			SRC_NONE:  emit = 1'b0;
			SRC_F: begin
				emit  = 1'b1;
				obyte = CH_F;
			end
			SRC_TWO: begin
				emit  = 1'b1;
				obyte = CH_TWO;
			end
			SRC_TYPE: begin
				emit  = 1'b1;
				obyte = type_q;
			end
			SRC_SEMI: begin
				emit  = 1'b1;
				obyte = CH_SEMI;
			end
			SRC_SIGN: begin
				emit  = neg_q;
				obyte = CH_MINUS;
			end
			SRC_DIGIT: begin
				// leading zeros dropped, units always printed
				emit  = started_q || (digit != 4'd0) || (uop.place == PLACE_UNIT);
				obyte = CH_ZERO + 8'(digit);
			end
			SRC_TAIL: begin
				emit = 1'b1;
				if (last_q) begin
					obyte = CH_NUL;
					olast = 1'b1;
					close = 1'b1;
				end else begin
					obyte = CH_SEMI;
				end
			end
		endcase
		unique case (uop.jmp)
			JMP_NEXT:     pc_nxt = pc_q + 4'd1;
			JMP_DISPATCH: pc_nxt = open_q ? PC_SIGN : PC_HDR;
			JMP_HOME:     pc_nxt = PC_HOME;
			JMP_OVF: begin
				// frame too long: flag the last digit, skip the terminator
				if (last_q && ovf_hit) begin
					olast  = 1'b1;
					ouser  = 1'b1;
					close  = 1'b1;
					pc_nxt = PC_HOME;
				end
			end
		endcase
		bump = emit && !(uop.src == SRC_TAIL && last_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q      <= PC_HOME;
			open_q    <= 1'b0;
			count_q   <= '0;
			started_q <= 1'b0;
			m_tvalid  <= 1'b0;
		end else begin
			if (step_go && emit) begin
				m_tvalid <= 1'b1;
			end else if (m_tready) begin
				m_tvalid <= 1'b0;
			end
			if (s_req) begin
				pc_q      <= pc_nxt;
				open_q    <= 1'b1;
				started_q <= 1'b0;
			end else if (step_go) begin
				pc_q <= pc_nxt;
				if (uop.src == SRC_DIGIT) begin
					started_q <= started_q || emit;
				end
				if (close) begin
					open_q  <= 1'b0;
					count_q <= '0;
				end else if (bump && count_q != {CNT_W{1'b1}}) begin
					count_q <= count_q + 11'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_req) begin
			type_q <= s_tdata[7:0];
			neg_q  <= raw_val[15];
			mag_q  <= raw_val[15] ? (~raw_val + 16'd1) : raw_val;
			last_q <= s_tlast;
		end else if (step_go && uop.src == SRC_DIGIT) begin
			mag_q <= mag_q - sub[15:0];
		end
		if (step_go && emit) begin
			m_tdata <= obyte;
			m_tlast <= olast;
			m_tuser <= ouser;
		end
	end

	`ADFB_ASSERT_NOW(a_ovf_on_end, m_tvalid && m_tuser, m_tlast, "overflow without frame end")
	`ADFB_ASSERT_NEXT(a_close, step_go && emit && olast, !open_q && count_q == '0,
		"frame not closed after final byte")
	`ADFB_ASSERT_NEXT(a_dispatch, s_req && !open_q, pc_q == PC_HDR, "new frame skipped header")
	`ADFB_ASSERT_NEXT(a_resume, s_req && open_q, pc_q == PC_SIGN, "open frame repeated header")

endmodule
